### rtl/core/arsb_pkg.sv
package arsb_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int AGE_W      = SLOT_W;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	localparam int KIND_W   = 2;
	localparam int DATA_W   = 32;
	localparam int SIM_W    = 16;
	localparam int IDX_W    = 3;
	localparam int STATUS_W = 3;
	localparam int RANK_W   = 4;
	localparam int OCC_W    = 4;

	localparam logic signed [SIM_W-1:0]  THRESH_RESET = 16'sd190;
	localparam logic signed [RANK_W-1:0] RANK_EMPTY   = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQUEUE = 2'd0,
		KIND_REMOVE  = 2'd1,
		KIND_DISABLE = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_DISABLED  = 3'd2,
		ST_INVALID   = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_READ      = 3'd5
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic              clear;
		logic              dec_en;
		logic [AGE_W-1:0]  dec_thr;
		logic [AGE_W-1:0]  wr_age;
		logic [AGE_W-1:0]  newest_age;
		logic [DATA_W-1:0] wr_data;
	} cell_cmd_t;

	// per-cell view handed back to the controller
	typedef struct packed {
		logic             used;
		logic [AGE_W-1:0] age;
		logic             first_free;
		logic             first_newest;
		logic             oldest;
	} cell_st_t;

endpackage

### rtl/core/arsb_in_if.sv
interface arsb_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [arsb_pkg::KIND_W-1:0]            kind;
	logic [arsb_pkg::DATA_W-1:0]            payload;
	logic signed [arsb_pkg::SIM_W-1:0]      similarity;
	logic [arsb_pkg::IDX_W-1:0]             slot_index;

	modport source (output valid, kind, payload, similarity, slot_index, input ready);
	modport sink (input valid, kind, payload, similarity, slot_index, output ready);
endinterface

### rtl/core/arsb_out_if.sv
interface arsb_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [arsb_pkg::STATUS_W-1:0]          status;
	logic [arsb_pkg::IDX_W-1:0]             slot_written;
	logic signed [arsb_pkg::RANK_W-1:0]     slot_rank;
	logic [arsb_pkg::DATA_W-1:0]            payload_out;
	logic [arsb_pkg::OCC_W-1:0]             occupied_count;

	modport source (output valid, status, slot_written, slot_rank, payload_out,
		occupied_count, input ready);
	modport sink (input valid, status, slot_written, slot_rank, payload_out,
		occupied_count, output ready);
endinterface

### rtl/core/age_ranked_sample_buffer.sv
// Age-ranked sample buffer: a row of slot cells, each holding one payload word
// and its age rank (0 = oldest).
// in_ch carries one operation per item: enqueue (with similarity score against
// the newest entry), remove slot, disable, or read slot. out_ch returns exactly
// one result item per operation: status, slot, rank after the step, read data
// and occupancy.
// Throughput is one item per cycle while the receiver keeps taking results. The
// free-slot and newest-slot searches ripple through the cell row, and the whole
// operation is applied at the same edge that accepts the item. The result sits
// in the output register the cycle after acceptance.
// If the receiver stalls, the result holds in the output register and in_ch
// accepts a new item only once that register is taken or empty.
// cfg_wr_en/cfg_wr_data write the duplicate threshold (signed, reset 190);
// write it only while the block is idle.
// Reset empties every slot, re-enables the buffer and drops any pending result.
// A disable empties the buffer and locks it until the next reset.
module age_ranked_sample_buffer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic signed [arsb_pkg::SIM_W-1:0]     cfg_wr_data,
	arsb_in_if.sink                               in_ch,
	arsb_out_if.source                            out_ch
);

	logic signed [arsb_pkg::SIM_W-1:0]  thr_q;
	logic                               disabled_q;
	logic [arsb_pkg::CNT_W-1:0]         cnt_q;

	logic                               out_valid_q;
	arsb_pkg::status_t                  status_q;
	logic [arsb_pkg::IDX_W-1:0]         slot_q;
	logic signed [arsb_pkg::RANK_W-1:0] rank_q;
	logic [arsb_pkg::DATA_W-1:0]        rdata_q;
	logic [arsb_pkg::OCC_W-1:0]         occ_q;

	logic                               accept;
	arsb_pkg::cell_cmd_t                cmd;
	arsb_pkg::cell_st_t                 st [arsb_pkg::SLOT_COUNT];
	logic [arsb_pkg::DATA_W-1:0]        cdata [arsb_pkg::SLOT_COUNT];
	logic [arsb_pkg::SLOT_COUNT:0]      free_chain;
	logic [arsb_pkg::SLOT_COUNT:0]      newest_chain;
	logic [arsb_pkg::SLOT_COUNT-1:0]    sel_wr;
	logic [arsb_pkg::SLOT_COUNT-1:0]    sel_free;
	logic [arsb_pkg::SLOT_COUNT-1:0]    used_vec;

	logic [arsb_pkg::SLOT_W-1:0]        free_idx;
	logic [arsb_pkg::SLOT_W-1:0]        newest_idx;
	logic [arsb_pkg::SLOT_W-1:0]        oldest_idx;
	logic [arsb_pkg::SLOT_W-1:0]        dest_idx;
	logic [arsb_pkg::SLOT_W-1:0]        tgt_idx;
	logic                               full;
	logic                               dup;
	logic                               tgt_ok;
	logic                               wr_en;
	logic                               free_en;
	logic                               set_disabled;
	arsb_pkg::status_t                  nx_status;
	logic [arsb_pkg::IDX_W-1:0]         nx_slot;
	logic signed [arsb_pkg::RANK_W-1:0] nx_rank;
	logic [arsb_pkg::DATA_W-1:0]        nx_data;
	logic [arsb_pkg::CNT_W-1:0]         nx_cnt;

	assign accept       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = !out_valid_q || out_ch.ready;

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.slot_written   = slot_q;
	assign out_ch.slot_rank      = rank_q;
	assign out_ch.payload_out    = rdata_q;
	assign out_ch.occupied_count = occ_q;

	assign free_chain[0]   = 1'b0;
	assign newest_chain[0] = 1'b0;

	for (genvar i = 0; i < arsb_pkg::SLOT_COUNT; i++) begin : g_cell
		arsb_cell u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.upd             (accept),
			.cmd             (cmd),
			.sel_wr          (sel_wr[i]),
			.sel_free        (sel_free[i]),
			.free_seen_in    (free_chain[i]),
			.newest_seen_in  (newest_chain[i]),
			.free_seen_out   (free_chain[i+1]),
			.newest_seen_out (newest_chain[i+1]),
			.st              (st[i]),
			.data            (cdata[i])
		);
		assign used_vec[i] = st[i].used;
		assign sel_wr[i]   = wr_en && (dest_idx == arsb_pkg::SLOT_W'(i));
		assign sel_free[i] = free_en && (tgt_idx == arsb_pkg::SLOT_W'(i));
	end

	// slot searches; first-free and first-newest are one-hot from the chain
	always_comb begin
		free_idx   = '0;
		newest_idx = '0;
		oldest_idx = '0;
		for (int i = 0; i < arsb_pkg::SLOT_COUNT; i++) begin
			if (st[i].first_free) free_idx = arsb_pkg::SLOT_W'(i);
			if (st[i].first_newest) newest_idx = arsb_pkg::SLOT_W'(i);
			if (st[i].oldest) oldest_idx = arsb_pkg::SLOT_W'(i);
		end
	end

	assign full     = !free_chain[arsb_pkg::SLOT_COUNT];
	assign dest_idx = full ? oldest_idx : free_idx;
	assign dup      = (cnt_q != '0) && (in_ch.similarity > thr_q);
	assign tgt_idx  = arsb_pkg::SLOT_W'(in_ch.slot_index);
	assign tgt_ok   = (int'(in_ch.slot_index) < arsb_pkg::SLOT_COUNT) && st[tgt_idx].used;

	always_comb begin
		cmd.clear      = 1'b0;
		cmd.dec_en     = 1'b0;
		cmd.dec_thr    = '0;
		cmd.wr_age     = full ? arsb_pkg::AGE_W'(arsb_pkg::SLOT_COUNT - 1)
		                      : cnt_q[arsb_pkg::AGE_W-1:0];
		cmd.newest_age = arsb_pkg::AGE_W'(cnt_q - 1'b1);
		cmd.wr_data    = in_ch.payload;
		wr_en          = 1'b0;
		free_en        = 1'b0;
		set_disabled   = 1'b0;
		nx_status      = arsb_pkg::ST_DISABLED;
		nx_slot        = '0;
		nx_rank        = arsb_pkg::RANK_EMPTY;
		nx_data        = '0;
		nx_cnt         = cnt_q;

		if (arsb_pkg::kind_t'(in_ch.kind) == arsb_pkg::KIND_DISABLE) begin
			cmd.clear    = 1'b1;
			set_disabled = 1'b1;
			nx_cnt       = '0;
		end else if (!disabled_q) begin
			case (arsb_pkg::kind_t'(in_ch.kind))
				arsb_pkg::KIND_ENQUEUE: begin
					if (dup) begin
						nx_status = arsb_pkg::ST_DUPLICATE;
						nx_slot   = arsb_pkg::IDX_W'(newest_idx);
						if (newest_chain[arsb_pkg::SLOT_COUNT]) begin
							nx_rank = arsb_pkg::RANK_W'(st[newest_idx].age);
						end
					end else begin
						wr_en      = 1'b1;
						cmd.dec_en = full;
						nx_status  = arsb_pkg::ST_ENQUEUED;
						nx_slot    = arsb_pkg::IDX_W'(dest_idx);
						nx_rank    = arsb_pkg::RANK_W'(cmd.wr_age);
						nx_cnt     = full ? cnt_q : cnt_q + 1'b1;
					end
				end
				arsb_pkg::KIND_REMOVE: begin
					nx_slot = in_ch.slot_index;
					if (tgt_ok) begin
						free_en     = 1'b1;
						cmd.dec_en  = 1'b1;
						cmd.dec_thr = st[tgt_idx].age;
						nx_status   = arsb_pkg::ST_REMOVED;
						nx_cnt      = cnt_q - 1'b1;
					end else begin
						nx_status = arsb_pkg::ST_INVALID;
					end
				end
				arsb_pkg::KIND_READ: begin
					nx_slot = in_ch.slot_index;
					if (tgt_ok) begin
						nx_status = arsb_pkg::ST_READ;
						nx_rank   = arsb_pkg::RANK_W'(st[tgt_idx].age);
						nx_data   = cdata[tgt_idx];
					end else begin
						nx_status = arsb_pkg::ST_INVALID;
					end
				end
				default: begin
					nx_status = arsb_pkg::ST_DISABLED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= arsb_pkg::THRESH_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disabled_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= nx_cnt;
				if (set_disabled) disabled_q <= 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= nx_status;
			slot_q   <= nx_slot;
			rank_q   <= nx_rank;
			rdata_q  <= nx_data;
			occ_q    <= arsb_pkg::OCC_W'(nx_cnt);
		end
	end

`ifndef SYNTHESIS
	a_cnt_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_vec) == int'(cnt_q))
		else $error("occupancy count out of step with slot flags");

	a_disabled_empty: assert property (@(posedge clk) disable iff (!arst_n)
		disabled_q |-> (cnt_q == '0))
		else $error("disabled buffer holds entries");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	a_newest_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> newest_chain[arsb_pkg::SLOT_COUNT])
		else $error("no slot carries the newest rank");
`endif

endmodule

### rtl/core/arsb_cell.sv
module arsb_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  arsb_pkg::cell_cmd_t           cmd,
	input  logic                          sel_wr,
	input  logic                          sel_free,
	input  logic                          free_seen_in,
	input  logic                          newest_seen_in,
	output logic                          free_seen_out,
	output logic                          newest_seen_out,
	output arsb_pkg::cell_st_t            st,
	output logic [arsb_pkg::DATA_W-1:0]   data
);

	logic                         used_q;
	logic [arsb_pkg::AGE_W-1:0]   age_q;
	logic [arsb_pkg::DATA_W-1:0]  data_q;
	logic                         newest_match;

	assign newest_match    = used_q && (age_q == cmd.newest_age);
	assign free_seen_out   = free_seen_in || !used_q;
	assign newest_seen_out = newest_seen_in || newest_match;

	assign st.used         = used_q;
	assign st.age          = age_q;
	assign st.first_free   = !used_q && !free_seen_in;
	assign st.first_newest = newest_match && !newest_seen_in;
	assign st.oldest       = used_q && (age_q == '0);
	assign data            = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			age_q  <= '0;
		end else if (upd) begin
			if (cmd.clear) begin
				used_q <= 1'b0;
				age_q  <= '0;
			end else if (sel_wr) begin
				used_q <= 1'b1;
				age_q  <= cmd.wr_age;
			end else if (sel_free) begin
				used_q <= 1'b0;
				age_q  <= '0;
			end else if (cmd.dec_en && used_q && (age_q > cmd.dec_thr)) begin
				age_q <= age_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd && !cmd.clear && sel_wr) begin
			data_q <= cmd.wr_data;
		end
	end

endmodule

### tb/age_ranked_sample_buffer_tb.sv
module age_ranked_sample_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arsb_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 65;

	typedef struct {
		status_t                   status;
		logic [IDX_W-1:0]          slot;
		logic signed [RANK_W-1:0]  rank;
		logic [DATA_W-1:0]         data;
		logic [OCC_W-1:0]          count;
	} buffer_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic signed [SIM_W-1:0]  cfg_wr_data;

	arsb_in_if  in_ch();
	arsb_out_if out_ch();

	age_ranked_sample_buffer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	// shadow copy of the buffer contents
	bit                       slot_busy [SLOT_COUNT];
	int                       slot_age_q [SLOT_COUNT];
	logic [DATA_W-1:0]        slot_word [SLOT_COUNT];
	bit                       locked;
	logic signed [SIM_W-1:0]  dup_limit;

	buffer_result_t pending_results[$];
	int             errors;
	int             cycles;
	bit             in_burst;
	bit             fill_bias;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int occupancy();
		int n;
		n = 0;
		for (int i = 0; i < SLOT_COUNT; i++)
			n += slot_busy[i];
		return n;
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_busy[i]  = 1'b0;
			slot_age_q[i] = 0;
		end
	endfunction

	// applies one operation to the shadow buffer and returns its result
	function automatic buffer_result_t next_buffer_result(kind_t k, logic [DATA_W-1:0] data,
			logic signed [SIM_W-1:0] sim, logic [IDX_W-1:0] idx);
		buffer_result_t r;
		int n, newest, oldest, dest, gone;
		bit found;
		r.data = '0;
		r.rank = RANK_EMPTY;
		r.slot = '0;
		if (k == KIND_DISABLE) begin
			clear_slots();
			locked = 1'b1;
			r.status = ST_DISABLED;
		end else if (locked) begin
			r.status = ST_DISABLED;
		end else if (k == KIND_ENQUEUE) begin
			n = occupancy();
			newest = 0;
			oldest = 0;
			dest = SLOT_COUNT;
			found = 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slot_busy[i]) begin
					if (!found && slot_age_q[i] == n - 1) begin
						newest = i;
						found = 1'b1;
					end
					if (slot_age_q[i] == 0)
						oldest = i;
				end else if (dest == SLOT_COUNT) begin
					dest = i;
				end
			end
			if (n != 0 && sim > dup_limit) begin
				r.status = ST_DUPLICATE;
				r.slot = IDX_W'(newest);
				if (found)
					r.rank = RANK_W'(slot_age_q[newest]);
			end else begin
				if (dest == SLOT_COUNT) begin
					// full: oldest entry drops out, everyone else ages
					dest = oldest;
					for (int i = 0; i < SLOT_COUNT; i++)
						if (slot_busy[i] && slot_age_q[i] != 0)
							slot_age_q[i]--;
					slot_age_q[dest] = SLOT_COUNT - 1;
				end else begin
					slot_age_q[dest] = n;
				end
				slot_busy[dest] = 1'b1;
				slot_word[dest] = data;
				r.status = ST_ENQUEUED;
				r.slot = IDX_W'(dest);
				r.rank = RANK_W'(slot_age_q[dest]);
			end
		end else if (!slot_busy[idx]) begin
			r.status = ST_INVALID;
			r.slot = idx;
		end else if (k == KIND_REMOVE) begin
			gone = slot_age_q[idx];
			slot_busy[idx] = 1'b0;
			slot_age_q[idx] = 0;
			for (int i = 0; i < SLOT_COUNT; i++)
				if (slot_busy[i] && slot_age_q[i] > gone)
					slot_age_q[i]--;
			r.status = ST_REMOVED;
			r.slot = idx;
		end else begin
			r.status = ST_READ;
			r.slot = idx;
			r.rank = RANK_W'(slot_age_q[idx]);
			r.data = slot_word[idx];
		end
		r.count = OCC_W'(occupancy());
		return r;
	endfunction

	task automatic flag_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	task automatic check_result();
		buffer_result_t e;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual status %0d slot %0d",
				$time, out_ch.status, out_ch.slot_written);
			errors++;
		end else begin
			e = pending_results.pop_front();
			if (out_ch.status !== e.status)
				flag_field("status", e.status, out_ch.status);
			if (out_ch.slot_written !== e.slot)
				flag_field("slot_written", e.slot, out_ch.slot_written);
			if (out_ch.slot_rank !== e.rank)
				flag_field("slot_rank", RANK_W'(e.rank), RANK_W'(out_ch.slot_rank));
			if (out_ch.payload_out !== e.data)
				flag_field("payload_out", e.data, out_ch.payload_out);
			if (out_ch.occupied_count !== e.count)
				flag_field("occupied_count", e.count, out_ch.occupied_count);
		end
	endtask

	// result side: sample at the falling edge, drive ready at the rising edge
	initial begin
		int stall;
		bit out_burst;
		stall = 0;
		out_burst = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				check_result();
			@(posedge clk);
			if ($urandom_range(0, 39) == 0)
				out_burst = !out_burst;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
				if (!out_burst)
					stall = pick_gap();
			end
		end
	end

	// called at a rising edge; returns at the edge that takes the item, valid left high
	task automatic send_op(kind_t k, logic [DATA_W-1:0] data, logic signed [SIM_W-1:0] sim,
			logic [IDX_W-1:0] idx);
		int gap;
		if ($urandom_range(0, 39) == 0)
			in_burst = !in_burst;
		gap = in_burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= k;
		in_ch.payload    <= data;
		in_ch.similarity <= sim;
		in_ch.slot_index <= idx;
		do
			@(negedge clk);
		while (!in_ch.ready);
		pending_results.push_back(next_buffer_result(k, data, sim, idx));
		@(posedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic signed [SIM_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dup_limit = value;
	endtask

	task automatic test_fill_and_wrap();
		// empty buffer ignores similarity
		send_op(KIND_ENQUEUE, 32'hFFFF_FFFF, 16'sd32767, 3'd0);
		send_op(KIND_ENQUEUE, 32'h0000_0000, 16'sd191, 3'd0);
		send_op(KIND_ENQUEUE, 32'h0000_0000, 16'sd190, 3'd7);
		for (int i = 0; i < 6; i++)
			send_op(KIND_ENQUEUE, $urandom, -16'sd32768, 3'd0);
		// full: overwrites the oldest
		send_op(KIND_ENQUEUE, 32'hA5A5_5A5A, 16'sd0, 3'd0);
	endtask

	task automatic test_remove_and_read();
		send_op(KIND_READ, '0, '0, 3'd0);
		send_op(KIND_READ, '0, '0, 3'd7);
		send_op(KIND_REMOVE, '0, '0, 3'd3);
		send_op(KIND_READ, '0, '0, 3'd3);
		send_op(KIND_REMOVE, '0, '0, 3'd3);
		send_op(KIND_READ, '0, '0, 3'd4);
		send_op(KIND_ENQUEUE, 32'h1234_5678, -16'sd1, 3'd0);
	endtask

	task automatic test_threshold_extremes();
		write_threshold(-16'sd32768);
		send_op(KIND_ENQUEUE, $urandom, -16'sd32768, 3'd0);
		send_op(KIND_ENQUEUE, $urandom, -16'sd32767, 3'd0);
		write_threshold(16'sd32767);
		send_op(KIND_ENQUEUE, $urandom, 16'sd32767, 3'd0);
	endtask

	function automatic logic signed [SIM_W-1:0] pick_similarity();
		int lim, r, s;
		lim = dup_limit;
		r = $urandom_range(0, 99);
		if (r < 60)
			s = int'($urandom_range(0, lim + 32768)) - 32768;
		else if (r < 80)
			s = lim + int'($urandom_range(0, 2)) - 1;
		else
			s = int'($urandom_range(0, 65535)) - 32768;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return SIM_W'(s);
	endfunction

	function automatic logic [IDX_W-1:0] pick_slot();
		int held[$];
		for (int i = 0; i < SLOT_COUNT; i++)
			if (slot_busy[i])
				held.push_back(i);
		if (held.size() != 0 && $urandom_range(0, 99) < 85)
			return IDX_W'(held[$urandom_range(0, held.size() - 1)]);
		return IDX_W'($urandom_range(0, SLOT_COUNT - 1));
	endfunction

	task automatic test_random_traffic();
		logic signed [SIM_W-1:0] limits [RANDOM_PHASES];
		int r;
		kind_t k;
		limits[0] = THRESH_RESET;
		limits[1] = 16'sd0;
		limits[2] = SIM_W'($urandom);
		limits[3] = -16'sd32768;
		limits[4] = 16'sd32767;
		limits[5] = SIM_W'($urandom);
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_threshold(limits[p]);
			// the lowest setting freezes the buffer, keep that phase short
			for (int i = 0; i < (p == 3 ? 15 : PHASE_ITEMS + 10); i++) begin
				if ($urandom_range(0, 19) == 0)
					fill_bias = !fill_bias;
				r = $urandom_range(0, 99);
				if (fill_bias)
					k = (r < 70) ? KIND_ENQUEUE : (r < 85) ? KIND_REMOVE : KIND_READ;
				else
					k = (r < 20) ? KIND_ENQUEUE : (r < 70) ? KIND_REMOVE : KIND_READ;
				send_op(k, $urandom, pick_similarity(), pick_slot());
			end
		end
	endtask

	// disable locks the buffer until reset, so this runs last
	task automatic test_disable();
		send_op(KIND_DISABLE, $urandom, SIM_W'($urandom), 3'd5);
		send_op(KIND_ENQUEUE, $urandom, -16'sd32768, 3'd0);
		send_op(KIND_REMOVE, '0, '0, 3'd0);
		send_op(KIND_READ, '0, '0, 3'd0);
		send_op(KIND_DISABLE, '0, '0, 3'd0);
	endtask

	initial begin
		errors = 0;
		in_burst = 1'b0;
		fill_bias = 1'b1;
		clear_slots();
		locked = 1'b0;
		dup_limit = THRESH_RESET;
		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.kind       <= KIND_ENQUEUE;
		in_ch.payload    <= '0;
		in_ch.similarity <= '0;
		in_ch.slot_index <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_wrap();
		test_remove_and_read();
		test_threshold_extremes();
		test_random_traffic();
		test_disable();

		drain_results();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
